[src/pbps_pkg.sv]
// ----------------------------------------------------------------------------
// pbps_pkg
// Shared types, constants and helper functions for the packed bit pair store.
// ----------------------------------------------------------------------------
package pbps_pkg;

	localparam int WORD_BITS   = 8;
	localparam int STORE_WORDS = 4096;
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int WALK_W      = ADDR_W + 1;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int HALF_BITS   = WORD_BITS / 2;
	localparam int SIZE_W      = 16;
	localparam int POS_W       = 15;

	localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(STORE_WORDS * WORD_BITS);
	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STORE_WORDS - 1);

	// operation codes
	localparam logic [3:0] MODE_CLEAR_ALL = 4'd0;
	localparam logic [3:0] MODE_SET_BIT   = 4'd1;
	localparam logic [3:0] MODE_CLR_BIT   = 4'd2;
	localparam logic [3:0] MODE_OR_PAIR   = 4'd3;
	localparam logic [3:0] MODE_CLR_PAIR  = 4'd4;
	localparam logic [3:0] MODE_GET_BIT   = 4'd5;
	localparam logic [3:0] MODE_GET_PAIR  = 4'd6;
	localparam logic [3:0] MODE_COUNT     = 4'd7;
	localparam logic [3:0] MODE_COMPACT   = 4'd8;

	// status codes
	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_RANGE      = 2'd1;
	localparam logic [1:0] ST_NO_COMPACT = 2'd2;

	// config register indexes
	localparam logic CFG_SIZE = 1'b0;
	localparam logic CFG_PAIR = 1'b1;

	// upper bit of every pair, and a single pair
	localparam logic [WORD_BITS-1:0] UPPER_MASK = WORD_BITS'(8'hAA);
	localparam logic [WORD_BITS-1:0] PAIR_MASK  = WORD_BITS'(3);

	typedef struct packed {
		logic [3:0]       mode;
		logic [POS_W-1:0] position;
		logic [1:0]       pair_value;
	} pbps_in_t;

	typedef struct packed {
		logic [1:0]        read_value;
		logic [SIZE_W-1:0] ones_count;
		logic [1:0]        status;
		logic [POS_W-1:0]  compacted_size;
	} pbps_out_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [WORD_BITS-1:0] wdata;
		logic                 re;
		logic [ADDR_W-1:0]    raddr;
	} pbps_mem_req_t;

	typedef struct packed {
		logic      valid;
		pbps_out_t res;
	} pbps_fin_t;

	function automatic logic [BIT_W:0] pop_word(input logic [WORD_BITS-1:0] w);
		logic [BIT_W:0] c;
		c = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			c = c + (BIT_W+1)'(w[k]);
		end
		return c;
	endfunction

	// lower bit of every pair, packed densely
	function automatic logic [HALF_BITS-1:0] even_bits(input logic [WORD_BITS-1:0] w);
		logic [HALF_BITS-1:0] r;
		r = '0;
		for (int k = 0; k < HALF_BITS; k++) begin
			r[k] = w[2*k];
		end
		return r;
	endfunction

endpackage

[src/pbps_mem.sv]
// ----------------------------------------------------------------------------
// pbps_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbps_mem
	import pbps_pkg::*;
(
	input  logic                 clk,
	input  pbps_mem_req_t        req,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [STORE_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

[src/pbps_seq.sv]
// ----------------------------------------------------------------------------
// pbps_seq
// Operation sequencer: read-modify-write of single words, store walks for
// clear, count, compaction check, packing and tail zeroing.
// ----------------------------------------------------------------------------
module pbps_seq
	import pbps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  pbps_in_t             item,
	input  logic [SIZE_W-1:0]    size_in_bits,
	input  logic                 pair_format,
	input  logic                 slot_free,
	output pbps_fin_t            fin,
	output pbps_mem_req_t        req,
	input  logic [WORD_BITS-1:0] rdata
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CLR  = 8'b0000_0010,
		S_RMW  = 8'b0000_0100,
		S_CNT  = 8'b0000_1000,
		S_CHK  = 8'b0001_0000,
		S_PACK = 8'b0010_0000,
		S_ZERO = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	pbps_in_t          op_q;
	logic [WALK_W-1:0] walk_q;
	logic [WALK_W-1:0] lim_q;
	logic [1:0]        phase_q;
	logic [SIZE_W-1:0] acc_q;
	logic [HALF_BITS-1:0] lo_q;
	logic              rd_pend_q;
	logic              clr_rsp_q;
	pbps_out_t         res_q;

	logic [SIZE_W-1:0]  eff_size;
	logic [WALK_W-1:0]  used_words;
	logic [POS_W-1:0]   entries;
	logic [ADDR_W-1:0]  new_words;
	logic [SIZE_W:0]    size_round;
	logic [POS_W:0]     entries_round;
	logic               issue;
	logic               pack_active;
	logic [SIZE_W-1:0]  in_pair_hi;
	logic [SIZE_W-1:0]  op_pair_b;
	logic [ADDR_W-1:0]  op_addr;
	logic [BIT_W-1:0]   op_off;
	logic               op_is_pair;
	logic [WORD_BITS-1:0] tail_mask;
	logic [BIT_W-1:0]   tail_bits;

	assign eff_size      = (size_in_bits > SIZE_CAP) ? SIZE_CAP : size_in_bits;
	assign size_round    = {1'b0, eff_size} + (SIZE_W+1)'(WORD_BITS - 1);
	assign used_words    = WALK_W'(size_round >> BIT_W);
	assign entries       = POS_W'(eff_size >> 1);
	assign entries_round = {1'b0, entries} + (POS_W+1)'(WORD_BITS - 1);
	assign new_words     = ADDR_W'(entries_round >> BIT_W);
	assign tail_bits     = entries[BIT_W-1:0];

	assign in_pair_hi = {item.position, 1'b1};

	// word address and bit offset of the pending single access
	assign op_is_pair = (op_q.mode == MODE_OR_PAIR) || (op_q.mode == MODE_CLR_PAIR) ||
		(op_q.mode == MODE_GET_PAIR);
	assign op_pair_b  = {op_q.position, 1'b0};
	assign op_addr    = op_is_pair ? op_pair_b[BIT_W +: ADDR_W] : op_q.position[BIT_W +: ADDR_W];
	assign op_off     = op_is_pair ? op_pair_b[BIT_W-1:0] : op_q.position[BIT_W-1:0];

	assign issue       = walk_q < lim_q;
	assign pack_active = walk_q < WALK_W'(new_words);

	// last packed word keeps only the entries below the new size
	always_comb begin
		tail_mask = '1;
		if (walk_q[ADDR_W-1:0] == new_words - ADDR_W'(1) && tail_bits != '0) begin
			tail_mask = ~({WORD_BITS{1'b1}} << tail_bits);
		end
	end

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		fin     = '0;
		req     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					case (item.mode) inside
						MODE_CLEAR_ALL: begin
							state_d = S_CLR;
						end
						MODE_SET_BIT, MODE_CLR_BIT, MODE_GET_BIT: begin
							if ({1'b0, item.position} >= eff_size) begin
								fin.valid      = 1'b1;
								fin.res.status = ST_RANGE;
							end else begin
								req.re    = 1'b1;
								req.raddr = item.position[BIT_W +: ADDR_W];
								state_d   = S_RMW;
							end
						end
						MODE_OR_PAIR, MODE_CLR_PAIR, MODE_GET_PAIR: begin
							if (in_pair_hi >= eff_size) begin
								fin.valid      = 1'b1;
								fin.res.status = ST_RANGE;
							end else begin
								req.re    = 1'b1;
								req.raddr = item.position[BIT_W-1 +: ADDR_W];
								state_d   = S_RMW;
							end
						end
						MODE_COUNT: begin
							if (item.position >= POS_W'(used_words)) begin
								fin.valid = 1'b1;
							end else begin
								state_d = S_CNT;
							end
						end
						MODE_COMPACT: begin
							if (!pair_format) begin
								fin.valid      = 1'b1;
								fin.res.status = ST_NO_COMPACT;
							end else begin
								state_d = S_CHK;
							end
						end
						default: begin
							fin.valid = 1'b1;
						end
					endcase
				end
			end
			S_CLR: begin
				req.we    = 1'b1;
				req.waddr = walk_q[ADDR_W-1:0];
				if (walk_q[ADDR_W-1:0] == LAST_WORD) begin
					if (clr_rsp_q) begin
						fin.valid = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_RMW: begin
				fin.valid = 1'b1;
				req.waddr = op_addr;
				case (op_q.mode)
					MODE_SET_BIT: begin
						req.we    = 1'b1;
						req.wdata = rdata | (WORD_BITS'(1) << op_off);
					end
					MODE_CLR_BIT: begin
						req.we    = 1'b1;
						req.wdata = rdata & ~(WORD_BITS'(1) << op_off);
					end
					MODE_OR_PAIR: begin
						req.we    = 1'b1;
						req.wdata = rdata | (WORD_BITS'(op_q.pair_value) << op_off);
					end
					MODE_CLR_PAIR: begin
						req.we    = 1'b1;
						req.wdata = rdata & ~(PAIR_MASK << op_off);
					end
					MODE_GET_BIT: begin
						fin.res.read_value = {1'b0, rdata[op_off]};
					end
					MODE_GET_PAIR: begin
						fin.res.read_value = 2'((rdata >> op_off) & PAIR_MASK);
					end
					default: begin
						fin.res = '0;
					end
				endcase
			end
			S_CNT: begin
				req.re    = issue;
				req.raddr = walk_q[ADDR_W-1:0];
				if (!issue && !rd_pend_q) begin
					fin.valid          = 1'b1;
					fin.res.ones_count = acc_q;
				end
			end
			S_CHK: begin
				req.re    = issue;
				req.raddr = walk_q[ADDR_W-1:0];
				if (rd_pend_q && (rdata & UPPER_MASK) != '0) begin
					fin.valid      = 1'b1;
					fin.res.status = ST_NO_COMPACT;
				end else if (!issue && !rd_pend_q) begin
					state_d = S_PACK;
				end
			end
			S_PACK: begin
				if (pack_active) begin
					// source words 2d and 2d+1 feed destination word d
					req.raddr = {walk_q[ADDR_W-2:0], phase_q[0]};
					req.waddr = walk_q[ADDR_W-1:0];
					req.wdata = {even_bits(rdata), lo_q} & tail_mask;
					req.re    = (phase_q != 2'd2);
					req.we    = (phase_q == 2'd2);
				end else begin
					state_d = S_ZERO;
				end
			end
			S_ZERO: begin
				req.we    = 1'b1;
				req.waddr = walk_q[ADDR_W-1:0];
				if (walk_q[ADDR_W-1:0] == LAST_WORD) begin
					fin.valid              = 1'b1;
					fin.res.compacted_size = entries;
				end
			end
			S_FIN: begin
				fin.valid = 1'b1;
				fin.res   = res_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin.valid) begin
			state_d = slot_free ? S_IDLE : S_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			walk_q    <= '0;
			rd_pend_q <= 1'b0;
			clr_rsp_q <= 1'b0;
			phase_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						walk_q    <= (item.mode == MODE_COUNT) ?
							item.position[WALK_W-1:0] : '0;
						rd_pend_q <= 1'b0;
						clr_rsp_q <= 1'b1;
						phase_q   <= '0;
					end
				end
				S_CLR, S_ZERO: begin
					walk_q <= walk_q + WALK_W'(1);
				end
				S_CNT, S_CHK: begin
					rd_pend_q <= issue;
					if (issue) begin
						walk_q <= walk_q + WALK_W'(1);
					end else if (!rd_pend_q) begin
						walk_q  <= '0;
						phase_q <= '0;
					end
				end
				S_PACK: begin
					if (pack_active) begin
						if (phase_q == 2'd2) begin
							phase_q <= '0;
							walk_q  <= walk_q + WALK_W'(1);
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				default: begin
					rd_pend_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			res_q <= fin.res;
		end
		if (state_q == S_IDLE && item_valid) begin
			op_q  <= item;
			acc_q <= '0;
			lim_q <= used_words;
		end
		if (state_q == S_CNT && rd_pend_q) begin
			acc_q <= acc_q + SIZE_W'(pop_word(rdata));
		end
		if (state_q == S_PACK && phase_q == 2'd1) begin
			lo_q <= even_bits(rdata);
		end
	end

endmodule

[src/packed_bit_pair_store.sv]
// ----------------------------------------------------------------------------
// packed_bit_pair_store
// Bit addressed store of words with bit and pair access, count and compaction.
// ----------------------------------------------------------------------------
// single bit and pair operations: one memory read, then a write back (set and
//   clear only) through the single read and write port pair of the word memory
// count: reads used words from the start word on; clear all: writes all words
// compact: checks used words, packs word pairs into new words, zeroes the rest
// result sits in an output register, so a new item may enter before it is taken
// reset: a full clearing pass runs with item_ready low; config writes work
module packed_bit_pair_store
	import pbps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  pbps_in_t          item,
	output logic              result_valid,
	input  logic              result_ready,
	output pbps_out_t         result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	logic [SIZE_W-1:0]    size_q;
	logic                 pair_q;
	logic                 out_valid_q;
	pbps_out_t            out_q;
	logic                 slot_free;
	pbps_fin_t            fin;
	pbps_mem_req_t        req;
	logic [WORD_BITS-1:0] rdata;

	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			pair_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE: size_q <= cfg_data;
				CFG_PAIR: pair_q <= cfg_data[0];
				default: size_q <= size_q;
			endcase
		end
	end

	// output transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin.valid && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid && slot_free) begin
			out_q <= fin.res;
		end
	end

	pbps_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.size_in_bits (size_q),
		.pair_format  (pair_q),
		.slot_free    (slot_free),
		.fin          (fin),
		.req          (req),
		.rdata        (rdata)
	);

	pbps_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule

[tb/tb_packed_bit_pair_store.sv]
// ----------------------------------------------------------------------------
// tb_packed_bit_pair_store
// Self-checking bench for the packed bit pair store. A shadow copy of the word
// store and the two config registers predicts every result in transaction
// order. Directed items cover edges and every operation, then random phases
// under several size and format settings, including clear-then-compact runs.
// ----------------------------------------------------------------------------
module tb_packed_bit_pair_store;
	import pbps_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	pbps_in_t          item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	pbps_out_t         result;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;

	packed_bit_pair_store uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// shadow state
	logic [WORD_BITS-1:0] shadow_words [STORE_WORDS];
	logic [SIZE_W-1:0]    cfg_size;
	logic                 cfg_pair;

	pbps_in_t    item_backlog [$];
	pbps_out_t   pending_results [$];
	int unsigned err_count;
	int unsigned cyc;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#32_000_000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// no idling at all inside one long window
	function automatic bit take_break();
		if (cyc >= 20000 && cyc < 50000) begin
			return 1'b0;
		end
		return $urandom_range(99) < 15;
	endfunction

	function automatic int eff_bits();
		return (cfg_size > SIZE_CAP) ? int'(SIZE_CAP) : int'(cfg_size);
	endfunction

	function automatic pbps_out_t store_op(pbps_in_t it);
		pbps_out_t            r;
		int                   eff, used, pos, b, entries, nw, e, cnt;
		bit                   blocked;
		logic [WORD_BITS-1:0] w;
		logic [WORD_BITS-1:0] snap [STORE_WORDS];
		r = '0;
		eff = eff_bits();
		used = (eff + WORD_BITS - 1) / WORD_BITS;
		pos = int'(it.position);
		b = 2 * pos;
		case (it.mode)
			MODE_CLEAR_ALL: begin
				foreach (shadow_words[i]) shadow_words[i] = '0;
			end
			MODE_SET_BIT, MODE_CLR_BIT, MODE_GET_BIT: begin
				if (pos >= eff) begin
					r.status = ST_RANGE;
				end else if (it.mode == MODE_SET_BIT) begin
					shadow_words[pos / WORD_BITS][pos % WORD_BITS] = 1'b1;
				end else if (it.mode == MODE_CLR_BIT) begin
					shadow_words[pos / WORD_BITS][pos % WORD_BITS] = 1'b0;
				end else begin
					r.read_value = {1'b0, shadow_words[pos / WORD_BITS][pos % WORD_BITS]};
				end
			end
			MODE_OR_PAIR, MODE_CLR_PAIR, MODE_GET_PAIR: begin
				if (b + 1 >= eff) begin
					r.status = ST_RANGE;
				end else if (it.mode == MODE_OR_PAIR) begin
					shadow_words[b / WORD_BITS][b % WORD_BITS +: 2] =
						shadow_words[b / WORD_BITS][b % WORD_BITS +: 2] | it.pair_value;
				end else if (it.mode == MODE_CLR_PAIR) begin
					shadow_words[b / WORD_BITS][b % WORD_BITS +: 2] = 2'b00;
				end else begin
					r.read_value = shadow_words[b / WORD_BITS][b % WORD_BITS +: 2];
				end
			end
			MODE_COUNT: begin
				cnt = 0;
				for (int i = pos; i < used; i++) cnt += $countones(shadow_words[i]);
				r.ones_count = SIZE_W'(cnt);
			end
			MODE_COMPACT: begin
				blocked = !cfg_pair;
				for (int i = 0; i < used; i++) begin
					if ((shadow_words[i] & UPPER_MASK) != '0) blocked = 1'b1;
				end
				if (blocked) begin
					r.status = ST_NO_COMPACT;
				end else begin
					entries = eff / 2;
					nw = (entries + WORD_BITS - 1) / WORD_BITS;
					snap = shadow_words;
					for (int d = 0; d < STORE_WORDS; d++) begin
						w = '0;
						for (int k = 0; k < WORD_BITS; k++) begin
							e = d * WORD_BITS + k;
							if (d < nw && e < entries)
								w[k] = snap[(2 * e) / WORD_BITS][(2 * e) % WORD_BITS];
						end
						shadow_words[d] = w;
					end
					r.compacted_size = POS_W'(entries);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_error(string what, int got, int want);
		$display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// driver: predicts each transaction as it is accepted
	always @(posedge clk) begin : drive
		pbps_in_t nxt_item;
		logic     nxt_valid;
		nxt_item = item;
		nxt_valid = item_valid;
		if (item_valid && item_ready) begin
			pending_results = {pending_results, store_op(item)};
			nxt_valid = 1'b0;
		end
		if (!nxt_valid && item_backlog.size() != 0 && !take_break()) begin
			nxt_item = item_backlog.pop_front();
			nxt_valid = 1'b1;
		end
		item_valid <= nxt_valid;
		item <= nxt_item;
	end

	// monitor
	always @(posedge clk) begin : watch
		pbps_out_t want;
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				flag_error("result with nothing pending, status", int'(result.status), -1);
			end else begin
				want = pending_results.pop_front();
				if (result.read_value != want.read_value)
					flag_error("read_value", int'(result.read_value), int'(want.read_value));
				if (result.ones_count != want.ones_count)
					flag_error("ones_count", int'(result.ones_count), int'(want.ones_count));
				if (result.status != want.status)
					flag_error("status", int'(result.status), int'(want.status));
				if (result.compacted_size != want.compacted_size)
					flag_error("compacted_size", int'(result.compacted_size),
						int'(want.compacted_size));
			end
		end
		result_ready <= !take_break();
	end

	task automatic push_op(logic [3:0] md, int pos, int pv);
		pbps_in_t it;
		it.mode = md;
		it.position = POS_W'(pos);
		it.pair_value = 2'(pv);
		item_backlog = {item_backlog, it};
	endtask

	// sample at the falling edge so the driver and monitor have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (item_backlog.size() != 0 || item_valid || pending_results.size() != 0);
		@(posedge clk);
	endtask

	// drain, then rewrite both registers in random order
	task automatic set_phase(int unsigned size, bit pair);
		logic [SIZE_W-1:0] pword;
		wait_idle();
		pword = SIZE_W'($urandom());
		pword[0] = pair;
		cfg_we <= 1'b1;
		if ($urandom_range(1)) begin
			cfg_index <= CFG_SIZE;
			cfg_data <= SIZE_W'(size);
			@(posedge clk);
			cfg_index <= CFG_PAIR;
			cfg_data <= pword;
			@(posedge clk);
		end else begin
			cfg_index <= CFG_PAIR;
			cfg_data <= pword;
			@(posedge clk);
			cfg_index <= CFG_SIZE;
			cfg_data <= SIZE_W'(size);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_size = SIZE_W'(size);
		cfg_pair = pair;
	endtask

	function automatic pbps_in_t pick_item(int eff);
		pbps_in_t it;
		int       roll, lim;
		roll = $urandom_range(99);
		if (roll == 0)
			it.mode = MODE_CLEAR_ALL;
		else if (roll <= 3)
			it.mode = MODE_COMPACT;
		else if (roll <= 6)
			it.mode = 4'($urandom_range(9, 15));
		else
			it.mode = 4'($urandom_range(1, 7));
		case (it.mode)
			MODE_OR_PAIR, MODE_CLR_PAIR, MODE_GET_PAIR: lim = eff / 2 + 1;
			MODE_COUNT: lim = (eff + WORD_BITS - 1) / WORD_BITS + 1;
			default: lim = eff + 2;
		endcase
		if (lim > 32767) lim = 32767;
		roll = $urandom_range(99);
		if (roll < 70)
			it.position = POS_W'($urandom_range(0, lim));
		else if (roll < 85)
			it.position = POS_W'($urandom());
		else if (roll < 92)
			it.position = POS_W'(lim);
		else if (roll < 96)
			it.position = '0;
		else
			it.position = '1;
		it.pair_value = 2'($urandom_range(3));
		return it;
	endfunction

	// clear, set only lower pair bits, then compact
	task automatic push_compact_run(int eff);
		int n, sel;
		push_op(MODE_CLEAR_ALL, $urandom_range(32767), $urandom_range(3));
		n = $urandom_range(3, 10);
		if (eff >= 2) begin
			for (int i = 0; i < n; i++) begin
				sel = $urandom_range(4);
				case (sel)
					0: push_op(MODE_OR_PAIR, $urandom_range(eff / 2 - 1), $urandom_range(1));
					1: push_op(MODE_SET_BIT, 2 * $urandom_range(eff / 2 - 1), 0);
					2: push_op(MODE_CLR_BIT, $urandom_range(eff - 1), 0);
					3: push_op(MODE_GET_PAIR, $urandom_range(eff / 2 - 1), 0);
					default: push_op(MODE_COUNT, 0, 0);
				endcase
			end
		end
		push_op(MODE_COMPACT, $urandom_range(32767), $urandom_range(3));
	endtask

	task automatic fill_random(int n, int nseq);
		for (int i = 0; i < n; i++) begin
			if (nseq > 0 && $urandom_range(n - 1) < nseq)
				push_compact_run(eff_bits());
			item_backlog = {item_backlog, pick_item(eff_bits())};
		end
	endtask

	initial begin
		foreach (shadow_words[i]) shadow_words[i] = '0;
		cfg_size = '0;
		cfg_pair = 1'b0;
		err_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_phase(64, 1'b1);
		push_op(MODE_CLEAR_ALL, 0, 0);
		push_op(MODE_SET_BIT, 0, 0);
		push_op(MODE_SET_BIT, 63, 0);
		push_op(MODE_SET_BIT, 64, 0);
		push_op(MODE_SET_BIT, 32767, 3);
		push_op(MODE_GET_BIT, 63, 0);
		push_op(MODE_GET_BIT, 64, 0);
		push_op(MODE_CLR_BIT, 63, 0);
		push_op(MODE_OR_PAIR, 0, 3);
		push_op(MODE_OR_PAIR, 31, 2);
		push_op(MODE_OR_PAIR, 32, 1);
		push_op(MODE_GET_PAIR, 0, 0);
		push_op(MODE_GET_PAIR, 31, 0);
		push_op(MODE_COUNT, 0, 0);
		push_op(MODE_COUNT, 7, 0);
		push_op(MODE_COUNT, 8, 0);
		push_op(MODE_COUNT, 32767, 0);
		push_op(MODE_COMPACT, 0, 0);
		push_op(MODE_CLR_PAIR, 0, 0);
		push_op(MODE_CLR_PAIR, 31, 0);
		push_op(MODE_COMPACT, 0, 0);
		push_op(4'd9, 0, 0);
		push_op(4'd15, 32767, 3);

		// compaction refused in 1-bit format
		set_phase(9, 1'b0);
		push_op(MODE_COMPACT, 0, 0);
		fill_random(150, 0);

		set_phase(0, 1'b1);
		fill_random(60, 1);

		set_phase(200, 1'b1);
		fill_random(280, 4);
		push_op(MODE_CLEAR_ALL, 0, 0);
		push_op(MODE_OR_PAIR, 3, 1);
		push_op(MODE_SET_BIT, 10, 0);
		push_op(MODE_SET_BIT, 198, 0);
		push_op(MODE_COMPACT, 0, 0);

		// software follows up a compaction with the halved size
		set_phase(100, 1'b0);
		fill_random(150, 0);

		set_phase(65535, 1'b1);
		fill_random(120, 1);

		set_phase(32768, 1'b0);
		fill_random(100, 0);

		set_phase(1000, 1'b1);
		fill_random(280, 3);

		set_phase(501, 1'b0);
		fill_random(200, 0);

		// odd size leaves slack bits from the last phase in the last word
		set_phase(17, 1'b1);
		fill_random(200, 3);

		set_phase(40000, 1'b0);
		fill_random(120, 0);

		wait_idle();
		repeat (64) @(posedge clk);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[packed_bit_pair_store.f]
src/pbps_pkg.sv
src/pbps_mem.sv
src/pbps_seq.sv
src/packed_bit_pair_store.sv
tb/tb_packed_bit_pair_store.sv
